// ----- rtl/core/dfcm_pkg.sv -----
// Shared constants and types for the DFCM double compressor.
package dfcm_pkg;

    localparam int HASH_BITS  = 16;
    localparam int ROWS       = 1 << HASH_BITS;
    localparam int VAL_W      = 64;
    localparam int ROW_W      = 2 * VAL_W;
    localparam int HASH_W     = 20;
    localparam int TOP_SHIFT  = 50;
    localparam int TOP_W      = VAL_W - TOP_SHIFT;
    localparam int DROP_SHIFT = 10;
    localparam int HASH_SHIFT = 5;
    localparam int BYTES_W    = 40;
    localparam int VALUES_W   = 37;
    localparam int NIB_W      = 4;
    localparam int BYTE_W     = 8;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // residual transfer from the predictor pipeline to the packer
    typedef struct packed {
        logic [VAL_W-1:0] x;
        logic             last;
    } t_resid;

endpackage

// ----- rtl/core/dfcm_ram.sv -----
// Generic simple dual-port RAM with registered read (read-first).
module dfcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- rtl/core/dfcm_predictor.sv -----
// Hash/delta table predictor: table clear, read-modify-write and residual pipeline.
module dfcm_predictor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [dfcm_pkg::VAL_W-1:0]  i_value_bits,
    input  logic                        i_last_value,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output dfcm_pkg::t_resid            o_res
);
    import dfcm_pkg::*;

    t_state r_state, n_state;
    logic [HASH_BITS-1:0] r_clr_addr;
    logic clr_we, run_ok;

    logic [HASH_W-1:0] r_hash;
    logic [VAL_W-1:0]  r_prev;
    logic [TOP_W-1:0]  r_tops [2];
    logic [TOP_W-1:0]  r_drop;
    logic              r_toggle;

    logic              r_s2_vld;
    logic [VAL_W-1:0]  r_s2_val, r_s2_diff, r_s2_prev;
    logic [HASH_BITS-1:0] r_s2_idx;
    logic              r_s2_last;

    logic              r_s3_vld;
    logic [VAL_W-1:0]  r_s3_base, r_s3_stride, r_s3_val;
    logic              r_s3_last;

    logic              r_s4_vld;
    logic [VAL_W-1:0]  r_s4_x;
    logic              r_s4_last;

    logic              r_fw_vld;
    logic [HASH_BITS-1:0] r_fw_idx;
    logic [ROW_W-1:0]  r_fw_row;

    logic                 ram_we;
    logic [HASH_BITS-1:0] ram_waddr;
    logic [ROW_W-1:0]     ram_wdata, ram_q;

    logic accept, s2_move, s3_move, s4_move, s2_free, s3_free, s4_free;
    logic [VAL_W-1:0]  diff, t0, t1, stride;
    logic [TOP_W-1:0]  top;
    logic [HASH_W-1:0] h_mix, hash_new;
    logic [ROW_W-1:0]  row;
    logic              fw_hit;

    // pipeline flow
    assign s4_move = r_s4_vld && i_res_ready;
    assign s4_free = !r_s4_vld || s4_move;
    assign s3_move = r_s3_vld && s4_free;
    assign s3_free = !r_s3_vld || s3_move;
    assign s2_move = r_s2_vld && s3_free;
    assign s2_free = !r_s2_vld || s2_move;
    assign o_in_ready = run_ok && s2_free;
    assign accept = i_in_valid && o_in_ready;

    // state machine: clearing pass, run, wait for final item's write-back
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_addr == '1) n_state = ST_RUN;
            ST_RUN:   if (accept && i_last_value) n_state = ST_DRAIN;
            ST_DRAIN: if (s2_move) n_state = ST_CLEAR;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        clr_we = 1'b0;
        run_ok = 1'b0;
        unique case (r_state)
            ST_CLEAR: clr_we = 1'b1;
            ST_RUN:   run_ok = 1'b1;
            ST_DRAIN: ;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (clr_we) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // stage 1: delta, context hash update
    assign diff     = i_value_bits - r_prev;
    assign top      = diff[VAL_W-1:TOP_SHIFT];
    assign h_mix    = r_hash ^ (HASH_W'(r_drop) << DROP_SHIFT);
    assign hash_new = (h_mix << HASH_SHIFT) ^ HASH_W'(top);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash    <= '0;
            r_prev    <= '0;
            r_tops[0] <= '0;
            r_tops[1] <= '0;
            r_drop    <= '0;
            r_toggle  <= 1'b0;
        end else if (accept) begin
            if (i_last_value) begin
                // stream restarts from the reset context
                r_hash    <= '0;
                r_prev    <= '0;
                r_tops[0] <= '0;
                r_tops[1] <= '0;
                r_drop    <= '0;
                r_toggle  <= 1'b0;
            end else begin
                r_hash           <= hash_new;
                r_prev           <= i_value_bits;
                r_drop           <= r_tops[r_toggle];
                r_tops[r_toggle] <= top;
                r_toggle         <= ~r_toggle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_val  <= i_value_bits;
            r_s2_diff <= diff;
            r_s2_prev <= r_prev;
            r_s2_idx  <= r_hash[HASH_BITS-1:0];
            r_s2_last <= i_last_value;
        end
    end

    // table row: {older delta, latest delta}
    dfcm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (r_hash[HASH_BITS-1:0]),
        .o_rdata (ram_q)
    );

    // stage 2: row from RAM or from the previous item's write-back
    assign fw_hit = r_fw_vld && (r_fw_idx == r_s2_idx);
    assign row    = fw_hit ? r_fw_row : ram_q;
    assign t0     = row[VAL_W-1:0];
    assign t1     = row[ROW_W-1:VAL_W];
    assign stride = (t0[VAL_W-1:TOP_SHIFT] == t1[VAL_W-1:TOP_SHIFT]) ? (t0 - t1) : '0;

    assign ram_we    = clr_we || s2_move;
    assign ram_waddr = clr_we ? r_clr_addr : r_s2_idx;
    assign ram_wdata = clr_we ? '0 : {t0, r_s2_diff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_vld <= 1'b0;
        end else if (clr_we) begin
            r_fw_vld <= 1'b0;
        end else if (s2_move) begin
            r_fw_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_fw_idx <= r_s2_idx;
            r_fw_row <= {t0, r_s2_diff};
        end
    end

    // stages 2 to 4 valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_s2_vld <= 1'b1;
            end else if (s2_move) begin
                r_s2_vld <= 1'b0;
            end
            if (s2_move) begin
                r_s3_vld <= 1'b1;
            end else if (s3_move) begin
                r_s3_vld <= 1'b0;
            end
            if (s3_move) begin
                r_s4_vld <= 1'b1;
            end else if (s4_move) begin
                r_s4_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_s3_base   <= r_s2_prev + t0;
            r_s3_stride <= stride;
            r_s3_val    <= r_s2_val;
            r_s3_last   <= r_s2_last;
        end
        // stage 3: prediction and residual
        if (s3_move) begin
            r_s4_x    <= (r_s3_base + r_s3_stride) ^ r_s3_val;
            r_s4_last <= r_s3_last;
        end
    end

    assign o_res_valid = r_s4_vld;
    assign o_res.x     = r_s4_x;
    assign o_res.last  = r_s4_last;

    // the final item's write-back leaves the forward entry set for the first clear cycle
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (!r_s2_vld && (r_clr_addr == '0 || !r_fw_vld)))
        else $error("item or forwarded row present during table clear");

    a_drain_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> r_s2_vld)
        else $error("final item left the read stage without starting the clear");

    a_drain_to_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN && s2_move) |=> (r_state == ST_CLEAR && r_clr_addr == '0))
        else $error("clear pass did not start from row zero");

endmodule

// ----- rtl/core/dfcm_packer.sv -----
// Nibble packer: leading-zero code, residual bytes, flush and stream totals.
module dfcm_packer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_res_valid,
    output logic                          o_res_ready,
    input  dfcm_pkg::t_resid              i_res,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dfcm_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_item_end,
    output logic                          o_stream_end,
    output logic [dfcm_pkg::BYTES_W-1:0]  o_stream_bytes,
    output logic                          o_expanded
);
    import dfcm_pkg::*;

    function automatic logic [NIB_W-1:0] lead_zero_nibbles(input logic [VAL_W-1:0] x);
        logic [NIB_W-1:0] hi;
        hi = '0;
        for (int i = 0; i < VAL_W / NIB_W; i++) begin
            if (x[NIB_W*i +: NIB_W] != '0) begin
                hi = NIB_W'(i);
            end
        end
        return ~hi;
    endfunction

    logic              r_busy;
    logic [VAL_W-1:0]  r_word;
    logic [3:0]        r_rem;
    logic              r_odd;
    logic              r_last;
    logic              r_pend_vld;
    logic [NIB_W-1:0]  r_pend_nib;
    logic [BYTES_W-1:0]  r_bytes;
    logic [VALUES_W-1:0] r_vals;

    logic out_free, load, busy_emit, emit, emit_iend, emit_send, flush;
    logic [NIB_W-1:0]  lz;
    logic [4:0]        n_nib, c_nib;
    logic [VAL_W-1:0]  ld_word;
    logic [3:0]        ld_rem;
    logic [BYTE_W-1:0] first_byte, emit_byte;
    logic [BYTES_W-1:0]  bytes_inc;
    logic [VALUES_W-1:0] vals_inc;

    assign out_free    = !o_out_valid || i_out_ready;
    assign o_res_ready = !r_busy && out_free;
    assign load        = i_res_valid && o_res_ready;
    assign busy_emit   = r_busy && out_free;
    assign emit        = load || busy_emit;

    // load: count nibble and first byte go out at once
    assign lz    = lead_zero_nibbles(i_res.x);
    assign n_nib = 5'd16 - 5'(lz);

    always_comb begin
        if (r_pend_vld) begin
            first_byte = {r_pend_nib, lz};
            ld_word    = i_res.x;
            c_nib      = n_nib;
        end else begin
            first_byte = {lz, i_res.x[NIB_W-1:0]};
            ld_word    = i_res.x >> NIB_W;
            c_nib      = n_nib - 5'd1;
        end
    end

    assign ld_rem = 4'(c_nib >> 1) + 4'(i_res.last & c_nib[0]);

    // last odd nibble of a final item goes out alone in the high half
    assign flush     = (r_rem == 4'd1) && r_last && r_odd;
    assign emit_byte = load ? first_byte
                     : (flush ? {r_word[NIB_W-1:0], 4'h0} : r_word[BYTE_W-1:0]);
    assign emit_iend = load ? (ld_rem == '0) : (r_rem == 4'd1);
    assign emit_send = emit_iend && (load ? i_res.last : r_last);

    assign bytes_inc = r_bytes + 1'b1;
    assign vals_inc  = r_vals + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_pend_vld <= 1'b0;
            r_bytes    <= '0;
            r_vals     <= '0;
        end else begin
            if (load) begin
                r_busy <= (ld_rem != '0);
                if (ld_rem == '0) begin
                    r_pend_vld <= c_nib[0] && !i_res.last;
                end else begin
                    r_pend_vld <= 1'b0;
                end
            end else if (busy_emit && r_rem == 4'd1) begin
                r_busy     <= 1'b0;
                r_pend_vld <= r_odd && !r_last;
            end
            if (emit) begin
                if (emit_send) begin
                    r_bytes <= '0;
                    r_vals  <= '0;
                end else begin
                    r_bytes <= bytes_inc;
                    if (emit_iend) begin
                        r_vals <= vals_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word     <= ld_word;
            r_rem      <= ld_rem;
            r_odd      <= c_nib[0];
            r_last     <= i_res.last;
            r_pend_nib <= ld_word[NIB_W-1:0];
        end else if (busy_emit) begin
            r_rem <= r_rem - 4'd1;
            if (!flush) begin
                r_word <= r_word >> BYTE_W;
            end
            r_pend_nib <= r_word[BYTE_W +: NIB_W];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_out_byte     <= emit_byte;
            o_item_end     <= emit_iend;
            o_stream_end   <= emit_send;
            o_stream_bytes <= emit_send ? bytes_inc : '0;
            o_expanded     <= emit_send && (bytes_inc >= {vals_inc, 3'b000});
        end
    end

    a_busy_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem != '0))
        else $error("packer busy with no bytes left");

    a_pend_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_pend_vld)
        else $error("pending nibble kept while an item is being packed");

    a_stream_end_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stream_end) |-> o_item_end)
        else $error("stream end on a byte that does not close its item");

    a_reset_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_send) |=> (r_bytes == '0 && r_vals == '0 && !r_pend_vld))
        else $error("stream totals not cleared after the final byte");

endmodule

// ----- rtl/core/dfcm_double_compressor_core.sv -----
// The first byte of an item is registered in predictor stages 2, 3 and 4 and then in the
// packer output register; any of them can stall. Throughput: at most one output byte per
// cycle, held back while i_out_ready is low; an item makes 1 to 9 bytes, and the packer
// takes the next residual only after the last byte of the current one. Reset: synchronous,
// active low; the delta table is then swept one row a cycle over all 65536 rows
// (2^HASH_BITS) with input ready low, and the same sweep follows every item marked last.
module dfcm_double_compressor_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dfcm_pkg::VAL_W-1:0]    i_value_bits,
    input  logic                          i_last_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dfcm_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_item_end,
    output logic                          o_stream_end,
    output logic [dfcm_pkg::BYTES_W-1:0]  o_stream_bytes,
    output logic                          o_expanded
);
    import dfcm_pkg::*;

    t_resid res;
    logic   res_valid, res_ready;

    dfcm_predictor u_predictor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_value_bits (i_value_bits),
        .i_last_value (i_last_value),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    dfcm_packer u_packer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_res_valid    (res_valid),
        .o_res_ready    (res_ready),
        .i_res          (res),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_item_end     (o_item_end),
        .o_stream_end   (o_stream_end),
        .o_stream_bytes (o_stream_bytes),
        .o_expanded     (o_expanded)
    );

endmodule
